### hdl/cmc_pkg.sv
`timescale 1ns / 1ps

package cmc_pkg;

    localparam int ADDR_W     = 20;
    localparam int MIN_OFFSET = 2;
    localparam int MAX_OFFSET = 8;
    localparam int MAX_INDEX  = 10;
    localparam int MAX_WAYS   = 8;
    localparam int BLOCK_W    = ADDR_W - MIN_OFFSET;
    localparam int TAG_W      = BLOCK_W;
    localparam int SET_W      = MAX_INDEX;
    localparam int WAY_W      = $clog2(MAX_WAYS);
    localparam int SLOT_W     = SET_W + WAY_W;
    localparam int CAP_W      = SLOT_W + 1;
    localparam int SEEN_ROW_W = 32;
    localparam int SEEN_BIT_W = $clog2(SEEN_ROW_W);
    localparam int SEEN_ADR_W = BLOCK_W - SEEN_BIT_W;
    localparam int REG_W      = 4;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_INDEX  = 2'd1;
    localparam logic [1:0] REG_WAYS   = 2'd2;

    localparam logic [REG_W-1:0] RST_OFFSET = 4'd5;
    localparam logic [REG_W-1:0] RST_INDEX  = 4'd10;
    localparam logic [REG_W-1:0] RST_WAYS   = 4'd1;

    typedef enum logic [1:0] {
        OUT_HIT        = 2'd0,
        OUT_COMPULSORY = 2'd1,
        OUT_CAPACITY   = 2'd2,
        OUT_CONFLICT   = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [REG_W-1:0] offset;
        logic [REG_W-1:0] index;
        logic [REG_W-1:0] ways;
    } geom_t;

    typedef struct packed {
        logic             cmp_valid;
        logic [CAP_W-1:0] cmp_idx;
        logic             done;
        logic             found;
        logic [CAP_W-1:0] found_idx;
    } scan_stat_t;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } line_ent_t;

    typedef struct packed {
        logic               valid;
        logic [BLOCK_W-1:0] block;
    } shadow_ent_t;

endpackage

### hdl/cmc_if.sv
`timescale 1ns / 1ps

interface cmc_acc_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [cmc_pkg::ADDR_W-1:0] address;

    modport source (output valid, kind, address, input ready);
    modport sink (input valid, kind, address, output ready);
endinterface

interface cmc_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] outcome;
    logic       line_fill;
    logic       write_back;

    modport source (output valid, outcome, line_fill, write_back, input ready);
    modport sink (input valid, outcome, line_fill, write_back, output ready);
endinterface

### hdl/cmc_cfg.sv
`timescale 1ns / 1ps

module cmc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cmc_pkg::PADDR_W-1:0] paddr,
    input  logic [cmc_pkg::PDATA_W-1:0] pwdata,
    output logic [cmc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output cmc_pkg::geom_t              geom
);
    import cmc_pkg::*;

    logic [REG_W-1:0] offset_reg;
    logic [REG_W-1:0] index_reg;
    logic [REG_W-1:0] ways_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= RST_OFFSET;
            index_reg  <= RST_INDEX;
            ways_reg   <= RST_WAYS;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_OFFSET: offset_reg <= pwdata[REG_W-1:0];
                REG_INDEX:  index_reg  <= pwdata[REG_W-1:0];
                REG_WAYS:   ways_reg   <= pwdata[REG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_OFFSET: prdata = {{(PDATA_W-REG_W){1'b0}}, offset_reg};
            REG_INDEX:  prdata = {{(PDATA_W-REG_W){1'b0}}, index_reg};
            REG_WAYS:   prdata = {{(PDATA_W-REG_W){1'b0}}, ways_reg};
            default:    prdata = '0;
        endcase
    end

    // Out-of-range settings are clamped to the geometry the hardware holds.
    always_comb
    begin
        if (offset_reg < REG_W'(MIN_OFFSET))
            geom.offset = REG_W'(MIN_OFFSET);
        else if (offset_reg > REG_W'(MAX_OFFSET))
            geom.offset = REG_W'(MAX_OFFSET);
        else
            geom.offset = offset_reg;

        if (index_reg > REG_W'(MAX_INDEX))
            geom.index = REG_W'(MAX_INDEX);
        else
            geom.index = index_reg;

        if (ways_reg == '0)
            geom.ways = REG_W'(1);
        else if (ways_reg > REG_W'(MAX_WAYS))
            geom.ways = REG_W'(MAX_WAYS);
        else
            geom.ways = ways_reg;
    end

endmodule

### hdl/cmc_scan.sv
`timescale 1ns / 1ps

module cmc_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cmc_pkg::CAP_W-1:0]   count,
    input  logic [cmc_pkg::BLOCK_W-1:0] key,
    input  logic                        ent_valid,
    input  logic [cmc_pkg::BLOCK_W-1:0] ent_key,
    output logic [cmc_pkg::CAP_W-1:0]   rd_idx,
    output cmc_pkg::scan_stat_t         stat
);
    import cmc_pkg::*;

    logic             busy_reg;
    logic             pend_reg;
    logic [CAP_W-1:0] issue_reg;
    logic [CAP_W-1:0] pidx_reg;
    logic [CAP_W-1:0] count_reg;
    logic             done_reg;
    logic             found_reg;
    logic [CAP_W-1:0] found_idx_reg;
    logic             match;

    // The memory data for the entry issued last cycle is compared now.
    assign match  = pend_reg && ent_valid && (ent_key == key);
    assign rd_idx = issue_reg;

    assign stat.cmp_valid = pend_reg;
    assign stat.cmp_idx   = pidx_reg;
    assign stat.done      = done_reg;
    assign stat.found     = found_reg;
    assign stat.found_idx = found_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            issue_reg     <= '0;
            pidx_reg      <= '0;
            count_reg     <= '0;
            found_idx_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                pend_reg  <= 1'b0;
                issue_reg <= '0;
                count_reg <= count;
                found_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (match || (pend_reg && pidx_reg == count_reg - CAP_W'(1)))
                begin
                    busy_reg      <= 1'b0;
                    pend_reg      <= 1'b0;
                    done_reg      <= 1'b1;
                    found_reg     <= match;
                    found_idx_reg <= pidx_reg;
                end
                else if (issue_reg < count_reg)
                begin
                    pend_reg  <= 1'b1;
                    pidx_reg  <= issue_reg;
                    issue_reg <= issue_reg + CAP_W'(1);
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
            end
        end
    end

endmodule

### hdl/cache_miss_classifier_unit.sv
`timescale 1ns / 1ps

// Classifies each load or store against a write-back, write-allocate
// set-associative cache with round-robin replacement, and returns one result
// per access: hit, or compulsory, capacity or conflict miss, with line fill
// and write-back flags. After reset the block clears its memories and
// accepts no access meanwhile; configuration writes are taken at any time.
// For each access, one shared compare unit first walks the fully associative
// shadow store one entry per cycle (up to ways*sets entries, stopping at a
// match), then walks the ways of the addressed set. A result waits in an
// output register, and the next access is accepted while it does.
module cache_miss_classifier_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    cmc_acc_if.sink                     acc,
    cmc_res_if.source                   res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cmc_pkg::PADDR_W-1:0] paddr,
    input  logic [cmc_pkg::PDATA_W-1:0] pwdata,
    output logic [cmc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import cmc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_SH_GO,
        S_SH_WAIT,
        S_LN_GO,
        S_LN_WAIT,
        S_UPDATE
    } state_t;

    geom_t      geom;
    scan_stat_t scan;

    state_t             state_reg;
    logic [SLOT_W-1:0]  clr_cnt_reg;
    logic               store_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [BLOCK_W-1:0] block_reg;
    logic [SET_W-1:0]   set_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic               in_shadow_reg;
    logic               hit_reg;
    logic [WAY_W-1:0]   hit_way_reg;
    logic               vdirty_reg;
    logic [SLOT_W-1:0]  fp_reg;
    logic               res_valid_reg;
    outcome_t           outcome_reg;
    logic               fill_reg;
    logic               wb_reg;

    logic [SEEN_ROW_W-1:0] seen_mem [2**SEEN_ADR_W];
    line_ent_t             line_mem [2**SLOT_W];
    logic [WAY_W-1:0]      vict_mem [2**SET_W];
    shadow_ent_t           sh_mem [2**SLOT_W];

    logic [SEEN_ROW_W-1:0] seen_q;
    line_ent_t             line_q;
    logic [WAY_W-1:0]      vict_q;
    shadow_ent_t           sh_q;

    logic               clearing;
    logic               out_free;
    logic               upd;
    logic               shadow_phase;
    logic               scan_start;
    logic [CAP_W-1:0]   scan_count;
    logic [BLOCK_W-1:0] scan_key;
    logic               ent_valid;
    logic [BLOCK_W-1:0] ent_key;
    logic [CAP_W-1:0]   rd_idx;
    logic [WAY_W-1:0]   vp_eff;
    logic [WAY_W-1:0]   vp_next;
    logic [CAP_W-1:0]   fp_eff;
    logic [CAP_W-1:0]   fp_inc;
    logic               seen_bit;
    logic [ADDR_W-1:0]  shifted;
    logic [SET_W:0]     set_mask;
    outcome_t           outcome_next;

    cmc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom)
    );

    assign shadow_phase = (state_reg == S_SH_GO) || (state_reg == S_SH_WAIT);
    assign scan_start   = (state_reg == S_SH_GO) || (state_reg == S_LN_GO);
    assign scan_count   = shadow_phase ? cap_reg : CAP_W'(geom.ways);
    assign scan_key     = shadow_phase ? block_reg : tag_reg;
    assign ent_valid    = shadow_phase ? sh_q.valid : line_q.valid;
    assign ent_key      = shadow_phase ? sh_q.block : line_q.tag;

    cmc_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .count     (scan_count),
        .key       (scan_key),
        .ent_valid (ent_valid),
        .ent_key   (ent_key),
        .rd_idx    (rd_idx),
        .stat      (scan)
    );

    assign clearing = (state_reg == S_CLEAR);
    assign out_free = !res_valid_reg || res.ready;
    assign upd      = (state_reg == S_UPDATE) && out_free;

    assign shifted  = addr_reg >> geom.offset;
    assign set_mask = ((SET_W+1)'(1) << geom.index) - (SET_W+1)'(1);

    // A stale victim pointer beyond the ways in use falls back to way 0.
    assign vp_eff  = ({1'b0, vict_q} >= geom.ways) ? '0 : vict_q;
    assign vp_next = ({1'b0, vp_eff} + REG_W'(1) == geom.ways) ? '0 : vp_eff + WAY_W'(1);
    assign fp_eff  = ({1'b0, fp_reg} >= cap_reg) ? '0 : {1'b0, fp_reg};
    assign fp_inc  = fp_eff + CAP_W'(1);
    assign seen_bit = seen_q[block_reg[SEEN_BIT_W-1:0]];

    always_comb
    begin
        if (hit_reg)
            outcome_next = OUT_HIT;
        else if (!seen_bit)
            outcome_next = OUT_COMPULSORY;
        else if (in_shadow_reg)
            outcome_next = OUT_CONFLICT;
        else
            outcome_next = OUT_CAPACITY;
    end

    assign acc.ready      = (state_reg == S_IDLE);
    assign res.valid      = res_valid_reg;
    assign res.outcome    = outcome_reg;
    assign res.line_fill  = fill_reg;
    assign res.write_back = wb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            fp_reg        <= '0;
            res_valid_reg <= 1'b0;
            in_shadow_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (upd)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && res.ready)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
                    if (clr_cnt_reg == '1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (acc.valid)
                    begin
                        store_reg <= acc.kind;
                        addr_reg  <= acc.address;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    block_reg <= shifted[BLOCK_W-1:0];
                    set_reg   <= shifted[SET_W-1:0] & set_mask[SET_W-1:0];
                    tag_reg   <= shifted[BLOCK_W-1:0] >> geom.index;
                    cap_reg   <= CAP_W'(geom.ways) << geom.index;
                    state_reg <= S_SH_GO;
                end
                S_SH_GO:
                begin
                    state_reg <= S_SH_WAIT;
                end
                S_SH_WAIT:
                begin
                    if (scan.done)
                    begin
                        in_shadow_reg <= scan.found;
                        state_reg     <= S_LN_GO;
                    end
                end
                S_LN_GO:
                begin
                    vdirty_reg <= 1'b0;
                    state_reg  <= S_LN_WAIT;
                end
                S_LN_WAIT:
                begin
                    if (scan.cmp_valid && scan.cmp_idx[WAY_W-1:0] == vp_eff)
                        vdirty_reg <= line_q.valid && line_q.dirty;
                    if (scan.done)
                    begin
                        hit_reg     <= scan.found;
                        hit_way_reg <= scan.found_idx[WAY_W-1:0];
                        state_reg   <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    if (out_free)
                    begin
                        outcome_reg   <= outcome_next;
                        fill_reg      <= !hit_reg;
                        wb_reg        <= !hit_reg && vdirty_reg;
                        if (!in_shadow_reg)
                            fp_reg <= (fp_inc == cap_reg) ? '0 : fp_inc[SLOT_W-1:0];
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Memories: registered reads, and writes from either the clearing pass
    // or the update at the end of an access.
    always_ff @(posedge clk)
    begin
        seen_q <= seen_mem[block_reg[BLOCK_W-1:SEEN_BIT_W]];
        vict_q <= vict_mem[set_reg];
        line_q <= line_mem[{set_reg, rd_idx[WAY_W-1:0]}];
        sh_q   <= sh_mem[rd_idx[SLOT_W-1:0]];

        if (clearing)
        begin
            seen_mem[clr_cnt_reg] <= '0;
            line_mem[clr_cnt_reg] <= '0;
            vict_mem[clr_cnt_reg[SET_W-1:0]] <= '0;
            sh_mem[clr_cnt_reg]   <= '0;
        end
        else if (upd)
        begin
            seen_mem[block_reg[BLOCK_W-1:SEEN_BIT_W]] <=
                seen_q | (SEEN_ROW_W'(1) << block_reg[SEEN_BIT_W-1:0]);
            if (hit_reg)
            begin
                if (store_reg)
                    line_mem[{set_reg, hit_way_reg}] <= '{valid: 1'b1, dirty: 1'b1,
                                                          tag: tag_reg};
            end
            else
            begin
                line_mem[{set_reg, vp_eff}] <= '{valid: 1'b1, dirty: store_reg,
                                                 tag: tag_reg};
                vict_mem[set_reg] <= vp_next;
            end
            if (!in_shadow_reg)
                sh_mem[fp_eff[SLOT_W-1:0]] <= '{valid: 1'b1, block: block_reg};
        end
    end

`ifndef SYNTHESIS
    a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.outcome == OUT_HIT |-> !res.line_fill && !res.write_back)
        else $error("hit result flags a fill or write-back");

    a_miss_fills: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.outcome != OUT_HIT |-> res.line_fill)
        else $error("miss result without line fill");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !acc.ready)
        else $error("access accepted during clearing pass");

    a_scan_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        scan.done |=> !scan.done)
        else $error("scan completion held longer than one cycle");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cmc_pkg::*;

    typedef struct {
        logic        outcome_ok;
        outcome_t    outcome;
        logic        line_fill;
        logic        write_back;
    } access_result_t;

    typedef struct {
        int          off;
        int          idx;
        int          ways;
        logic        kind;
        logic [19:0] address;
        bit          typed;
        outcome_t    outcome;
        logic        line_fill;
        logic        write_back;
    } plan_row_t;

    typedef struct {
        int off;
        int idx;
        int ways;
        int count;
    } geom_phase_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    cmc_acc_if acc ();
    cmc_res_if res ();

    cache_miss_classifier_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc.sink),
        .res     (res.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: cache lines, round-robin pointers, seen map and shadow store.
    logic [TAG_W-1:0]   line_tag [MAX_WAYS*1024];
    bit                 line_vld [MAX_WAYS*1024];
    bit                 line_drt [MAX_WAYS*1024];
    int                 rr_ptr [1024];
    bit                 seen_map [1 << BLOCK_W];
    logic [BLOCK_W-1:0] shadow_blk [MAX_WAYS*1024];
    bit                 shadow_vld [MAX_WAYS*1024];
    int                 shadow_fill;
    logic [3:0]         geom_off;
    logic [3:0]         geom_idx;
    logic [3:0]         geom_ways;

    access_result_t pending_results [$];
    int             errors;
    bit             quiet;
    int             stall_left = 0;

    function automatic int eff_offset();
        if (geom_off < MIN_OFFSET) return MIN_OFFSET;
        if (geom_off > MAX_OFFSET) return MAX_OFFSET;
        return geom_off;
    endfunction

    function automatic int eff_index();
        return (geom_idx > MAX_INDEX) ? MAX_INDEX : geom_idx;
    endfunction

    function automatic int eff_ways();
        if (geom_ways == 0) return 1;
        if (geom_ways > MAX_WAYS) return MAX_WAYS;
        return geom_ways;
    endfunction

    function automatic access_result_t classify_access(input logic kind,
                                                       input logic [19:0] address);
        access_result_t r;
        int ob;
        int ib;
        int ways;
        int sets;
        int cap;
        int blk;
        int set_no;
        int tag;
        int base;
        int vp;
        int slot;
        int fp;
        bit hit;
        bit in_shadow;
        bit was_seen;
        ob = eff_offset();
        ib = eff_index();
        ways = eff_ways();
        sets = 1 << ib;
        cap = sets * ways;
        blk = address >> ob;
        set_no = blk & (sets - 1);
        tag = blk >> ib;
        base = set_no * MAX_WAYS;
        hit = 0;
        in_shadow = 0;
        was_seen = seen_map[blk];
        seen_map[blk] = 1;
        for (int j = 0; j < cap; j++)
        begin
            if (shadow_vld[j] && shadow_blk[j] == blk)
            begin
                in_shadow = 1;
                break;
            end
        end
        for (int w = 0; w < ways; w++)
        begin
            if (line_vld[base+w] && line_tag[base+w] == tag)
            begin
                hit = 1;
                if (kind)
                    line_drt[base+w] = 1;
                break;
            end
        end
        r.outcome_ok = 1;
        r.line_fill = 0;
        r.write_back = 0;
        if (hit)
        begin
            r.outcome = OUT_HIT;
        end
        else
        begin
            vp = rr_ptr[set_no];
            if (vp >= ways)
                vp = 0;
            slot = base + vp;
            if (!was_seen)
                r.outcome = OUT_COMPULSORY;
            else if (in_shadow)
                r.outcome = OUT_CONFLICT;
            else
                r.outcome = OUT_CAPACITY;
            r.line_fill = 1;
            r.write_back = line_vld[slot] && line_drt[slot];
            line_tag[slot] = tag;
            line_vld[slot] = 1;
            line_drt[slot] = kind;
            rr_ptr[set_no] = (vp + 1) % ways;
        end
        if (!in_shadow)
        begin
            fp = shadow_fill;
            if (fp >= cap)
                fp = 0;
            shadow_blk[fp] = blk;
            shadow_vld[fp] = 1;
            shadow_fill = (fp + 1) % cap;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: %s", $time, what);
        errors++;
    endtask

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200000000;
        $display("Mismatches found");
        $finish;
    end

    // Result checker: every transfer on the result side pops the oldest expectation.
    always @(posedge clk)
    begin
        access_result_t e;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no access pending");
            end
            else
            begin
                e = pending_results.pop_front();
                if (res.outcome !== e.outcome)
                    report_mismatch($sformatf("outcome %0d, expected %0d",
                                              res.outcome, e.outcome));
                if (res.line_fill !== e.line_fill)
                    report_mismatch($sformatf("line_fill %0b, expected %0b",
                                              res.line_fill, e.line_fill));
                if (res.write_back !== e.write_back)
                    report_mismatch($sformatf("write_back %0b, expected %0b",
                                              res.write_back, e.write_back));
            end
        end
    end

    // Random receiver back-pressure in bursts.
    always @(posedge clk)
    begin
        if (quiet)
        begin
            res.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            res.ready <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            res.ready <= 1'b0;
        end
        else
        begin
            res.ready <= 1'b1;
        end
    end

    task automatic apb_write(input logic [1:0] reg_id, input logic [3:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(reg_id) << 2;
        pwdata <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[3:0] !== value)
            report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                      reg_id, prdata[3:0], value));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Geometry changes only with the block idle.
    task automatic set_geometry(input int off, input int idx, input int ways);
        acc.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
        apb_write(REG_OFFSET, 4'(off));
        apb_write(REG_INDEX, 4'(idx));
        apb_write(REG_WAYS, 4'(ways));
        geom_off = 4'(off);
        geom_idx = 4'(idx);
        geom_ways = 4'(ways);
    endtask

    task automatic send_access(input logic kind, input logic [19:0] address,
                               input bit typed, input access_result_t typed_res);
        access_result_t r;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            acc.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        acc.valid <= 1'b1;
        acc.kind <= kind;
        acc.address <= address;
        do
            @(posedge clk);
        while (!acc.ready);
        r = classify_access(kind, address);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    function automatic logic [19:0] pick_address();
        int ob;
        ob = eff_offset();
        if ($urandom_range(0, 7) == 0)
            return 20'($urandom);
        // A small block pool keeps hits, conflicts and capacity misses frequent.
        return 20'(($urandom_range(0, 47) << ob) | ($urandom & ((1 << ob) - 1)));
    endfunction

    initial
    begin
        plan_row_t      plan [$];
        geom_phase_t    phases [$];
        access_result_t tr;
        int             n;
        errors = 0;
        quiet = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        acc.valid = 1'b0;
        acc.kind = 1'b0;
        acc.address = '0;
        geom_off = RST_OFFSET;
        geom_idx = RST_INDEX;
        geom_ways = RST_WAYS;
        shadow_fill = 0;
        for (int i = 0; i < MAX_WAYS*1024; i++)
        begin
            line_vld[i] = 0;
            line_drt[i] = 0;
            shadow_vld[i] = 0;
        end
        for (int i = 0; i < 1024; i++)
            rr_ptr[i] = 0;
        for (int i = 0; i < (1 << BLOCK_W); i++)
            seen_map[i] = 0;

        plan = '{
            // Reset geometry: direct mapped, 1024 sets, 32-byte lines.
            '{5, 10, 1, 1'b0, 20'h00000, 1, OUT_COMPULSORY, 1'b1, 1'b0},
            '{5, 10, 1, 1'b1, 20'h00000, 1, OUT_HIT,        1'b0, 1'b0},
            '{5, 10, 1, 1'b1, 20'hFFFFF, 1, OUT_COMPULSORY, 1'b1, 1'b0},
            '{5, 10, 1, 1'b0, 20'h08000, 1, OUT_COMPULSORY, 1'b1, 1'b1},
            '{5, 10, 1, 1'b0, 20'h00000, 1, OUT_CONFLICT,   1'b1, 1'b0},
            '{5, 10, 1, 1'b1, 20'h0001F, 1, OUT_HIT,        1'b0, 1'b0},
            // Out-of-range low settings saturate to one line of four bytes.
            '{0, 0, 0, 1'b0, 20'h40000, 1, OUT_COMPULSORY, 1'b1, 1'b1},
            '{0, 0, 0, 1'b0, 20'h40004, 1, OUT_COMPULSORY, 1'b1, 1'b0},
            '{0, 0, 0, 1'b0, 20'h40000, 1, OUT_CAPACITY,   1'b1, 1'b0},
            '{0, 0, 0, 1'b1, 20'h40000, 1, OUT_HIT,        1'b0, 1'b0},
            '{0, 0, 0, 1'b0, 20'h40004, 1, OUT_CAPACITY,   1'b1, 1'b1},
            // Out-of-range high settings saturate to the largest geometry; an in-range one follows.
            '{15, 15, 15, 1'b1, 20'hABCDE, 0, OUT_HIT, 1'b0, 1'b0},
            '{15, 15, 15, 1'b0, 20'h12345, 0, OUT_HIT, 1'b0, 1'b0},
            '{15, 15, 15, 1'b0, 20'hABC00, 0, OUT_HIT, 1'b0, 1'b0},
            '{3, 2, 3, 1'b1, 20'h00100, 0, OUT_HIT, 1'b0, 1'b0},
            '{3, 2, 3, 1'b0, 20'h00120, 0, OUT_HIT, 1'b0, 1'b0},
            '{3, 2, 3, 1'b0, 20'h00140, 0, OUT_HIT, 1'b0, 1'b0},
            '{3, 2, 3, 1'b0, 20'h00160, 0, OUT_HIT, 1'b0, 1'b0},
            '{3, 2, 3, 1'b0, 20'h00100, 0, OUT_HIT, 1'b0, 1'b0},
            '{3, 2, 3, 1'b1, 20'h00180, 0, OUT_HIT, 1'b0, 1'b0}
        };
        phases = '{
            '{2, 0, 1, 12}, '{3, 2, 2, 14}, '{4, 3, 4, 14}, '{8, 10, 8, 3},
            '{2, 1, 8, 14}, '{6, 0, 3, 12}, '{7, 4, 5, 12}, '{5, 2, 2, 20}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].off != geom_off || plan[i].idx != geom_idx
                || plan[i].ways != geom_ways)
                set_geometry(plan[i].off, plan[i].idx, plan[i].ways);
            tr.outcome_ok = 1;
            tr.outcome = plan[i].outcome;
            tr.line_fill = plan[i].line_fill;
            tr.write_back = plan[i].write_back;
            send_access(plan[i].kind, plan[i].address, plan[i].typed, tr);
        end

        foreach (phases[p])
        begin
            acc.valid <= 1'b0;
            set_geometry(phases[p].off, phases[p].idx, phases[p].ways);
            if (p == phases.size() - 1)
                quiet = 1;
            n = phases[p].count;
            for (int k = 0; k < n; k++)
            begin
                if (p == 2 && k == 6)
                begin
                    // Drain the pipeline completely before the next transfer.
                    acc.valid <= 1'b0;
                    wait (pending_results.size() == 0);
                    @(posedge clk);
                end
                send_access(1'($urandom), pick_address(), 0, tr);
            end
        end
        acc.valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### filelist.f
hdl/cmc_pkg.sv
hdl/cmc_if.sv
hdl/cmc_cfg.sv
hdl/cmc_scan.sv
hdl/cache_miss_classifier_unit.sv
sim/tb_top.sv
